FILE: src/bldf_pkg.sv
// Shared definitions for the backlight level, dim and fade controller.
// Holds field widths, event codes, register indexes, reset values and the
// command and status structs between the controller and the datapath.
package bldf_pkg;

    // Field widths of the stream words and registers.
    localparam int MODE_W  = 3;
    localparam int LEVEL_W = 8;
    localparam int PCT_W   = 7;
    localparam int DUR_W   = 12;

    // Cycle table size limits.
    localparam int MAX_LEVELS      = 4;
    localparam int LEVEL_COUNT_DEF = 4;

    // APB register file geometry.
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_DIM_PERCENT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEVEL_0     = 3'd1;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET [MAX_LEVELS] =
        '{8'd64, 8'd128, 8'd192, 8'd255};

    // Event codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_SET       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CYCLE     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DIM       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NIGHT     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FADE_DOWN = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FADE_UP   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_TICK      = 3'd6;

    // Dimming scale: level * (100 - percent) / 100.
    localparam logic [PCT_W-1:0]   PCT_FULL = 7'd100;

    // Division by 100 as (x * 5243) >> 19, exact for x up to 25500.
    localparam int                 RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
    localparam int                 RECIP_SHIFT = 19;

    // Duration to step count: dur / 10 == (dur * 6554) >> 16 for 12-bit dur.
    localparam int                 DIV10_W     = 13;
    localparam logic [DIV10_W-1:0] DIV10_MUL   = 13'd6554;
    localparam int                 DIV10_SHIFT = 16;

    // Serial restoring divider: 16-bit dividend, 8-bit divisor.
    localparam int                   PROD_W    = 16;
    localparam int                   DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST  = 4'd15;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic decode;
        logic mul_load;
        logic div_step;
        logic finish;
        logic out_load;
    } bldf_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic need_div;
        logic var_div;
        logic fade_now;
        logic out_free;
    } bldf_sts_t;

endpackage

FILE: src/bldf_regs.sv
// APB register file: night dimming percent and the brightness cycle table.
// Depends on bldf_pkg for widths, register indexes and reset values.
module bldf_regs #(
    parameter int LEVEL_COUNT = bldf_pkg::LEVEL_COUNT_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [bldf_pkg::APB_AW-1:0]                 paddr,
    input  logic [bldf_pkg::APB_DW-1:0]                 pwdata,
    output logic [bldf_pkg::APB_DW-1:0]                 prdata,
    output logic [bldf_pkg::PCT_W-1:0]                  dim_percent,
    output logic [LEVEL_COUNT-1:0][bldf_pkg::LEVEL_W-1:0] level_tab
);

    logic                                        wr_en;
    logic [bldf_pkg::REG_IDX_W-1:0]              reg_idx;
    logic [bldf_pkg::PCT_W-1:0]                  dim_pct_reg;
    logic [LEVEL_COUNT-1:0][bldf_pkg::LEVEL_W-1:0] level_tab_reg;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[bldf_pkg::APB_AW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_pct_reg <= '0;
            for (int i = 0; i < LEVEL_COUNT; i++)
            begin
                level_tab_reg[i] <= bldf_pkg::LEVEL_RESET[i];
            end
        end
        else if (wr_en)
        begin
            if (reg_idx == bldf_pkg::REG_DIM_PERCENT)
            begin
                dim_pct_reg <= pwdata[bldf_pkg::PCT_W-1:0];
            end
            for (int i = 0; i < LEVEL_COUNT; i++)
            begin
                if (reg_idx == bldf_pkg::REG_LEVEL_0 + bldf_pkg::REG_IDX_W'(i))
                begin
                    level_tab_reg[i] <= pwdata[bldf_pkg::LEVEL_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == bldf_pkg::REG_DIM_PERCENT)
        begin
            prdata = bldf_pkg::APB_DW'(dim_pct_reg);
        end
        for (int i = 0; i < LEVEL_COUNT; i++)
        begin
            if (reg_idx == bldf_pkg::REG_LEVEL_0 + bldf_pkg::REG_IDX_W'(i))
            begin
                prdata = bldf_pkg::APB_DW'(level_tab_reg[i]);
            end
        end
    end

    assign dim_percent = dim_pct_reg;
    assign level_tab   = level_tab_reg;

endmodule

FILE: src/bldf_ctrl.sv
// Sequencing state machine: accept, decode, multiply, divide, finish, emit.
// Depends on bldf_pkg for the command and status structs.
module bldf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bldf_pkg::bldf_sts_t sts,
    output bldf_pkg::bldf_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [bldf_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [bldf_pkg::DIV_CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (sts.need_div)
                begin
                    state_next = S_MUL;
                end
                else if (sts.fade_now)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                cnt_next     = '0;
                // Only a fade step divides by a variable; the scale by 100 is
                // finished by a reciprocal multiply.
                if (sts.var_div)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == bldf_pkg::DIV_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_DECODE))
        else $error("accepted word did not move to decode");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == bldf_pkg::DIV_LAST) |=> (state_reg == S_FIN))
        else $error("divider did not finish after its last step");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");
`endif

endmodule

FILE: src/bldf_dp.sv
// Datapath: brightness and flag state, fade state, shared multiplier,
// serial divider and the output word register. Depends on bldf_pkg.
module bldf_dp #(
    parameter int LEVEL_COUNT = bldf_pkg::LEVEL_COUNT_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic [bldf_pkg::MODE_W-1:0]                   in_mode,
    input  logic [bldf_pkg::LEVEL_W-1:0]                  in_level,
    input  logic                                          in_flag,
    input  logic [bldf_pkg::DUR_W-1:0]                    in_duration_ms,
    input  logic [bldf_pkg::PCT_W-1:0]                    dim_percent,
    input  logic [LEVEL_COUNT-1:0][bldf_pkg::LEVEL_W-1:0] level_tab,
    input  bldf_pkg::bldf_cmd_t                           cmd,
    output bldf_pkg::bldf_sts_t                           sts,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [bldf_pkg::LEVEL_W-1:0]                  panel_level,
    output logic                                          level_written,
    output logic [bldf_pkg::LEVEL_W-1:0]                  user_level,
    output logic                                          dim_applied,
    output logic                                          fade_busy
);

    localparam int IDX_W  = $clog2(LEVEL_COUNT);
    localparam int DPRD_W = bldf_pkg::DUR_W + bldf_pkg::DIV10_W;
    localparam int SCL_W  = bldf_pkg::PROD_W + bldf_pkg::RECIP_W;
    localparam int LW     = bldf_pkg::LEVEL_W;

    // Captured input word.
    logic [bldf_pkg::MODE_W-1:0] mode_reg;
    logic [LW-1:0]               lvl_reg;
    logic                        flag_reg;
    logic [bldf_pkg::DUR_W-1:0]  dur_reg;

    // Controller state.
    logic [LW-1:0] user_reg;
    logic          dim_en_reg;
    logic          night_reg;
    logic          dimmed_reg;
    logic [LW-1:0] applied_reg;
    logic [LW-1:0] fstart_reg;
    logic [LW-1:0] ftarget_reg;
    logic [LW-1:0] fsteps_reg;
    logic [LW-1:0] findex_reg;
    logic          factive_reg;
    logic          wrote_reg;
    logic [LW-1:0] steps_new_reg;

    // Divider.
    logic [bldf_pkg::PROD_W-1:0] div_num_reg;
    logic [LW-1:0]               div_rem_reg;
    logic [LW-1:0]               div_den_reg;

    // Output word.
    logic          out_valid_reg;
    logic [LW-1:0] out_panel_reg;
    logic          out_written_reg;
    logic [LW-1:0] out_user_reg;
    logic          out_dim_reg;
    logic          out_fade_reg;

    // Combinational helpers.
    logic [IDX_W-1:0]            next_idx;
    logic                        hit;
    logic                        want_night;
    logic [bldf_pkg::PCT_W-1:0]  pct_sat;
    logic [bldf_pkg::PCT_W-1:0]  eff_factor;
    logic                        fade_up_dir;
    logic [LW-1:0]               delta;
    logic                        is_tick;
    logic [LW-1:0]               mul_a;
    logic [LW-1:0]               mul_b;
    logic [bldf_pkg::PROD_W-1:0] product;
    logic [SCL_W-1:0]            scaled_prod;
    logic [DPRD_W-1:0]           dur_prod;
    logic [DPRD_W-bldf_pkg::DIV10_SHIFT-1:0] steps_full;
    logic [LW-1:0]               steps_sat;
    logic [LW:0]                 rem_sh;
    logic [LW:0]                 rem_diff;
    logic                        rem_ge;
    logic [LW-1:0]               quot;
    logic [LW-1:0]               fade_tgt;

    // First table entry matching the user level picks the next one.
    always_comb
    begin
        next_idx = '0;
        hit      = 1'b0;
        for (int i = 0; i < LEVEL_COUNT; i++)
        begin
            if (!hit && level_tab[i] == user_reg)
            begin
                hit      = 1'b1;
                next_idx = (i == LEVEL_COUNT - 1) ? '0 : IDX_W'(i + 1);
            end
        end
    end

    assign want_night = dim_en_reg & flag_reg;

    assign pct_sat    = (dim_percent > bldf_pkg::PCT_FULL) ? bldf_pkg::PCT_FULL : dim_percent;
    assign eff_factor = dimmed_reg ? (bldf_pkg::PCT_FULL - pct_sat) : bldf_pkg::PCT_FULL;

    assign fade_up_dir = (ftarget_reg >= fstart_reg);
    assign delta       = fade_up_dir ? (ftarget_reg - fstart_reg) : (fstart_reg - ftarget_reg);

    // One shared 8x8 multiplier feeds the divider or the reciprocal scale.
    assign is_tick = (mode_reg == bldf_pkg::MODE_TICK);
    assign mul_a   = is_tick ? delta : user_reg;
    assign mul_b   = is_tick ? findex_reg : LW'(eff_factor);
    assign product = bldf_pkg::PROD_W'(mul_a) * bldf_pkg::PROD_W'(mul_b);

    // Registered product divided by 100 through the reciprocal.
    assign scaled_prod = SCL_W'(div_num_reg) * SCL_W'(bldf_pkg::RECIP_100);

    // Step count from the duration by reciprocal multiplication, saturated.
    assign dur_prod   = DPRD_W'(dur_reg) * DPRD_W'(bldf_pkg::DIV10_MUL);
    assign steps_full = dur_prod[DPRD_W-1:bldf_pkg::DIV10_SHIFT];
    assign steps_sat  = (steps_full > {1'b0, {LW{1'b1}}}) ? {LW{1'b1}} : steps_full[LW-1:0];

    // One restoring division step per cycle.
    assign rem_sh   = {div_rem_reg, div_num_reg[bldf_pkg::PROD_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, div_den_reg});
    assign rem_diff = rem_sh - {1'b0, div_den_reg};
    assign quot     = is_tick ? div_num_reg[LW-1:0]
                              : scaled_prod[bldf_pkg::RECIP_SHIFT +: LW];

    assign fade_tgt = (mode_reg == bldf_pkg::MODE_FADE_UP) ? quot : '0;

    always_comb
    begin
        sts.need_div = 1'b0;
        sts.var_div  = is_tick;
        sts.fade_now = (mode_reg == bldf_pkg::MODE_FADE_DOWN);
        sts.out_free = !out_valid_reg || out_ready;
        case (mode_reg)
            bldf_pkg::MODE_SET,
            bldf_pkg::MODE_CYCLE,
            bldf_pkg::MODE_FADE_UP:
            begin
                sts.need_div = 1'b1;
            end
            bldf_pkg::MODE_DIM:
            begin
                sts.need_div = ((flag_reg & night_reg) != dimmed_reg);
            end
            bldf_pkg::MODE_NIGHT:
            begin
                sts.need_div = (flag_reg != night_reg) && (want_night != dimmed_reg);
            end
            bldf_pkg::MODE_TICK:
            begin
                sts.need_div = factive_reg && (fsteps_reg != '0);
            end
            default:
            begin
                sts.need_div = 1'b0;
            end
        endcase
    end

    // Captured input word and scratch values carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= in_mode;
            lvl_reg  <= in_level;
            flag_reg <= in_flag;
            dur_reg  <= in_duration_ms;
        end
        if (cmd.decode)
        begin
            steps_new_reg <= steps_sat;
        end
        if (cmd.mul_load)
        begin
            div_num_reg <= product;
            div_rem_reg <= '0;
            div_den_reg <= fsteps_reg;
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= rem_ge ? rem_diff[LW-1:0] : rem_sh[LW-1:0];
            div_num_reg <= {div_num_reg[bldf_pkg::PROD_W-2:0], rem_ge};
        end
        if (cmd.out_load)
        begin
            out_panel_reg   <= applied_reg;
            out_written_reg <= wrote_reg;
            out_user_reg    <= user_reg;
            out_dim_reg     <= dimmed_reg;
            out_fade_reg    <= factive_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_reg      <= '0;
            dim_en_reg    <= 1'b0;
            night_reg     <= 1'b0;
            dimmed_reg    <= 1'b0;
            applied_reg   <= '0;
            fstart_reg    <= '0;
            ftarget_reg   <= '0;
            fsteps_reg    <= '0;
            findex_reg    <= '0;
            factive_reg   <= 1'b0;
            wrote_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.decode)
            begin
                wrote_reg <= 1'b0;
                // Every event but a tick or the unused code stops a fade.
                if (mode_reg <= bldf_pkg::MODE_FADE_UP)
                begin
                    factive_reg <= 1'b0;
                end
                case (mode_reg)
                    bldf_pkg::MODE_SET:
                    begin
                        user_reg  <= lvl_reg;
                        wrote_reg <= 1'b1;
                    end
                    bldf_pkg::MODE_CYCLE:
                    begin
                        user_reg  <= level_tab[next_idx];
                        wrote_reg <= 1'b1;
                    end
                    bldf_pkg::MODE_DIM:
                    begin
                        dim_en_reg <= flag_reg;
                        if ((flag_reg & night_reg) != dimmed_reg)
                        begin
                            dimmed_reg <= flag_reg & night_reg;
                            wrote_reg  <= 1'b1;
                        end
                    end
                    bldf_pkg::MODE_NIGHT:
                    begin
                        if (flag_reg != night_reg)
                        begin
                            night_reg <= flag_reg;
                            if (want_night != dimmed_reg)
                            begin
                                dimmed_reg <= want_night;
                                wrote_reg  <= 1'b1;
                            end
                        end
                    end
                    bldf_pkg::MODE_TICK:
                    begin
                        if (factive_reg && fsteps_reg != '0)
                        begin
                            findex_reg <= findex_reg + 1'b1;
                            wrote_reg  <= 1'b1;
                        end
                        else
                        begin
                            factive_reg <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.finish)
            begin
                case (mode_reg)
                    bldf_pkg::MODE_SET,
                    bldf_pkg::MODE_CYCLE,
                    bldf_pkg::MODE_DIM,
                    bldf_pkg::MODE_NIGHT:
                    begin
                        applied_reg <= quot;
                    end
                    bldf_pkg::MODE_FADE_DOWN,
                    bldf_pkg::MODE_FADE_UP:
                    begin
                        // Nothing to fade: jump to the target at once.
                        if (applied_reg == fade_tgt || steps_new_reg == '0)
                        begin
                            applied_reg <= fade_tgt;
                            wrote_reg   <= 1'b1;
                        end
                        else
                        begin
                            fstart_reg  <= applied_reg;
                            ftarget_reg <= fade_tgt;
                            fsteps_reg  <= steps_new_reg;
                            findex_reg  <= '0;
                            factive_reg <= 1'b1;
                        end
                    end
                    bldf_pkg::MODE_TICK:
                    begin
                        applied_reg <= fade_up_dir ? (fstart_reg + quot) : (fstart_reg - quot);
                        if (findex_reg >= fsteps_reg)
                        begin
                            factive_reg <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign panel_level   = out_panel_reg;
    assign level_written = out_written_reg;
    assign user_level    = out_user_reg;
    assign dim_applied   = out_dim_reg;
    assign fade_busy     = out_fade_reg;

`ifndef SYNTHESIS
    a_fade_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        factive_reg |-> (fsteps_reg != '0 && findex_reg <= fsteps_reg))
        else $error("running fade has an index past its step count");

    a_dim_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        dimmed_reg == (dim_en_reg && night_reg))
        else $error("dimmed flag disagrees with dim enable and night");
`endif

endmodule

FILE: src/backlight_level_dim_fade_control_top.sv
// Top level of the backlight level, dim and fade controller.
// Depends on bldf_pkg, bldf_regs, bldf_ctrl and bldf_dp.
//
//  Channel   Direction  Handshake                   Payload
//  s_axis    in         tvalid/tready               tuser: mode; tdata: level, flag, duration
//  m_axis    out        tvalid/tready               tdata: panel level and status bits
//  apb       in         psel/penable/pwrite/pready  dim_percent, level_0..level_3
//
// An event word passes from acceptance through decode straight to output when
// no arithmetic is needed, through finish for a fade down, through multiply and
// finish when the effective level is scaled through a reciprocal multiply, and
// through multiply, the 16 serial divider steps and finish for a fade step.
// Reset is asynchronous and active low; it clears all brightness, flag and
// fade state and loads the cycle table with 64, 128, 192 and 255.
// A stalled output holds its word while the next event word is accepted;
// that word's result waits until the output register is free.
module backlight_level_dim_fade_control_top #(
    parameter int LEVEL_COUNT = bldf_pkg::LEVEL_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    // Event words in.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] level, [8] flag, [20:9] duration_ms, [23:21] zero
    input  logic [23:0]                 s_axis_tdata,
    // [2:0] mode
    input  logic [2:0]                  s_axis_tuser,

    // Result words out.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] panel_level, [8] level_written, [16:9] user_level,
    // [17] dim_applied, [18] fade_busy, [23:19] zero
    output logic [23:0]                 m_axis_tdata,

    // Configuration.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bldf_pkg::APB_AW-1:0] paddr,
    input  logic [bldf_pkg::APB_DW-1:0] pwdata,
    output logic [bldf_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    logic [bldf_pkg::PCT_W-1:0]                    dim_percent;
    logic [LEVEL_COUNT-1:0][bldf_pkg::LEVEL_W-1:0] level_tab;
    bldf_pkg::bldf_cmd_t                           cmd;
    bldf_pkg::bldf_sts_t                           sts;

    logic [bldf_pkg::LEVEL_W-1:0] panel_level;
    logic                         level_written;
    logic [bldf_pkg::LEVEL_W-1:0] user_level;
    logic                         dim_applied;
    logic                         fade_busy;

    // The register file answers every access at once.
    assign pready = 1'b1;

    bldf_regs #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .dim_percent (dim_percent),
        .level_tab   (level_tab)
    );

    bldf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bldf_dp #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_mode        (s_axis_tuser),
        .in_level       (s_axis_tdata[7:0]),
        .in_flag        (s_axis_tdata[8]),
        .in_duration_ms (s_axis_tdata[20:9]),
        .dim_percent    (dim_percent),
        .level_tab      (level_tab),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .panel_level    (panel_level),
        .level_written  (level_written),
        .user_level     (user_level),
        .dim_applied    (dim_applied),
        .fade_busy      (fade_busy)
    );

    // Fields packed from the lowest bit up.
    assign m_axis_tdata = {5'b0, fade_busy, dim_applied, user_level,
                           level_written, panel_level};

endmodule
